// ===== rtl/smooth_vertex_normal_accumulator_macros.svh =====
// ----------------------------------------------------------------------------
// smooth vertex normal accumulator assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef SMOOTH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define SMOOTH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define SVNA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVNA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/svna_pkg.sv =====
// ----------------------------------------------------------------------------
// svna_pkg
// shared widths, codes and types of the smooth vertex normal accumulator
// ----------------------------------------------------------------------------
package svna_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int IDX_W            = 10;
  localparam int CFG_W            = 11;
  localparam int POS_W            = 32;
  localparam int SUM_W            = 32;
  localparam int CNT_W            = 16;
  localparam int NRM_W            = 16;
  localparam int NORMAL_ONE       = 16384;
  // divider: triangle numerator is below 2^45, denominator below 2^31
  localparam int DIV_NUM_W        = 45;
  localparam int DIV_DEN_W        = 32;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_TRIANGLE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FACES     = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } read_status_e;

  typedef enum logic [0:0] {
    CFG_FIRST_OUT    = 1'b0,
    CFG_VERTEX_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_POS_B,
    S_POS_C,
    S_EDGE,
    S_ESHIFT,
    S_CROSS,
    S_CRMAG,
    S_NORM,
    S_SQUARE,
    S_SQRT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_UPD_RD,
    S_UPD_WR,
    S_RD_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic        [CNT_W-1:0] cnt;
  } acc_t;

endpackage

// ===== rtl/svna_if.sv =====
// ----------------------------------------------------------------------------
// svna channel interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface svna_in_if import svna_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [IDX_W-1:0]        first_index;
  logic [IDX_W-1:0]        second_index;
  logic [IDX_W-1:0]        third_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, action, first_index, second_index, third_index,
                  output pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, action, first_index, second_index, third_index,
                  input pos_x, pos_y, pos_z, output ready);
endinterface

interface svna_out_if import svna_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [1:0]              read_status;

  modport source (output valid, normal_x, normal_y, normal_z, read_status, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, read_status, output ready);
endinterface

interface svna_cfg_if import svna_pkg::*;;
  logic             valid;
  logic             ready;
  logic [0:0]       index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/smooth_vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator
// per-vertex position store and face-normal accumulator with averaged readout
// ----------------------------------------------------------------------------
// usage:
//   in_i   items: write position, add triangle, read normal, clear accumulator
//   out_o  one result item per read action (averaged normal and status)
//   cfg_i  register writes: first output vertex, vertex count; always ready
// sequencing, one item at a time, in_i.ready high only while the sequencer idles:
//   write, clear, rejected triangle: done in the dispatch state
//   read: one run of the shared divider per component
//   triangle: runs the bit-serial square root (32 steps), the magnitude
//   normalization (one bit per cycle) and the divider once per component
//   degenerate triangle: no square root and no divider runs
//   out-of-range read: straight to the output register; zero-count read: no divider runs
// after reset the accumulator memory is swept to zero, one entry per cycle,
// with in_i.ready low until the sweep ends; register writes are taken throughout
// a stalled result waits in the output register; the next item is accepted
// meanwhile and only a following read result waits for it to drain
// ----------------------------------------------------------------------------
module smooth_vertex_normal_accumulator import svna_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  svna_cfg_if.sink   cfg_i,
  svna_in_if.sink    in_i,
  svna_out_if.source out_o
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  // ---------------------------------------------------------------- state
  state_e           state_q, state_d;
  logic [CFG_W-1:0] first_q, vcount_q;
  logic [AW-1:0]    clr_addr_q;
  logic [1:0]       ck_q;        // component or corner counter
  logic [2:0]       mstep_q;     // multiplier sequence step

  // latched item
  action_e          act_q;
  logic [IDX_W-1:0] idx_q [3];
  pos_t             wpos_q;

  // memories
  pos_t             pos_mem [MAX_VERTICES];
  acc_t             acc_mem [MAX_VERTICES];
  pos_t             pos_rd_q;
  acc_t             acc_rd_q;
  logic [AW-1:0]    pos_raddr, acc_raddr, acc_waddr;
  logic             pos_we, acc_we;
  acc_t             acc_wdata;

  // triangle datapath
  pos_t                pa_q, pb_q;
  logic                e_neg_q [6];
  logic [32:0]         e_mag_q [6];
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod_q;
  logic signed [63:0]  cr_q [3];
  logic                cr_neg_q [3];
  logic [62:0]         m_q [3];
  logic [63:0]         sq_x_q, sq_r_q, sq_bit_q, sq_t;

  // read datapath and result
  logic signed [SUM_W-1:0] sum_q [3];
  logic [CNT_W-1:0]        cnt_q;
  logic signed [NRM_W-1:0] n_q [3];
  read_status_e            res_status_q;

  // divider
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic [NRM_W-1:0]     q16;
  logic                 q_neg;

  // output register
  logic                    out_valid_q;
  logic signed [NRM_W-1:0] out_nx_q, out_ny_q, out_nz_q;
  read_status_e            out_status_q;

  // ---------------------------------------------------------------- helpers
  function automatic logic in_rng(input logic [IDX_W-1:0] i, input logic [CFG_W-1:0] vc);
    in_rng = (CFG_W'(i) < vc) && (int'(i) < MAX_VERTICES);
  endfunction

  function automatic logic signed [31:0] ev(input logic neg, input logic [32:0] mag);
    logic signed [31:0] v;
    v  = signed'({2'b00, mag[29:0]});
    ev = neg ? -v : v;
  endfunction

  logic tri_ok, rd_ok, e_big, m_zero, m_hi, m_lo, out_free;
  logic [2:0] cj;

  assign tri_ok = in_rng(idx_q[0], vcount_q) && in_rng(idx_q[1], vcount_q)
                  && in_rng(idx_q[2], vcount_q);
  assign rd_ok  = in_rng(idx_q[0], vcount_q) && (CFG_W'(idx_q[0]) >= first_q);

  // edge magnitudes must drop below 2^30 before the cross product
  assign e_big = (|e_mag_q[0][32:30]) | (|e_mag_q[1][32:30]) | (|e_mag_q[2][32:30])
               | (|e_mag_q[3][32:30]) | (|e_mag_q[4][32:30]) | (|e_mag_q[5][32:30]);

  // largest cross magnitude is brought into [2^29, 2^30)
  assign m_zero = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
  assign m_hi   = (|m_q[0][62:30]) | (|m_q[1][62:30]) | (|m_q[2][62:30]);
  assign m_lo   = !((|m_q[0][62:29]) | (|m_q[1][62:29]) | (|m_q[2][62:29]));

  assign out_free = !out_valid_q || out_o.ready;
  assign cj       = mstep_q - 3'd1;
  assign sq_t     = sq_r_q + sq_bit_q;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (clr_addr_q == AW'(MAX_VERTICES - 1)) state_d = S_IDLE;
      S_IDLE:     if (in_i.valid) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (act_q)
          ACT_TRIANGLE: state_d = tri_ok ? S_POS_B : S_IDLE;
          ACT_READ:     state_d = rd_ok ? S_RD_WAIT : S_OUT;
          default:      state_d = S_IDLE;
        endcase
      end
      S_POS_B:    state_d = S_POS_C;
      S_POS_C:    state_d = S_EDGE;
      S_EDGE:     state_d = S_ESHIFT;
      S_ESHIFT:   if (!e_big) state_d = S_CROSS;
      S_CROSS:    if (mstep_q == 3'd6) state_d = S_CRMAG;
      S_CRMAG:    state_d = S_NORM;
      S_NORM: begin
        priority if (m_zero)      state_d = S_UPD_RD;
        else if (m_hi || m_lo)    state_d = S_NORM;
        else                      state_d = S_SQUARE;
      end
      S_SQUARE:   if (mstep_q == 3'd3) state_d = S_SQRT;
      S_SQRT:     if (sq_bit_q == '0) state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          if (ck_q != 2'd2)          state_d = S_DIV_GO;
          else if (act_q == ACT_READ) state_d = S_OUT;
          else                        state_d = S_UPD_RD;
        end
      end
      S_UPD_RD:   state_d = S_UPD_WR;
      S_UPD_WR:   state_d = (ck_q == 2'd2) ? S_IDLE : S_UPD_RD;
      S_RD_WAIT:  state_d = (acc_rd_q.cnt == '0) ? S_OUT : S_DIV_GO;
      S_OUT:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    pos_we    = 1'b0;
    pos_raddr = AW'(idx_q[0]);
    acc_we    = 1'b0;
    acc_raddr = AW'(idx_q[0]);
    acc_waddr = AW'(idx_q[ck_q]);
    acc_wdata = acc_rd_q;
    div_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr_q;
        acc_wdata = '0;
      end
      S_DISPATCH: begin
        pos_we    = (act_q == ACT_WRITE) && in_rng(idx_q[0], vcount_q);
        acc_we    = (act_q == ACT_CLEAR) && in_rng(idx_q[0], vcount_q);
        acc_waddr = AW'(idx_q[0]);
        acc_wdata = '0;
      end
      S_POS_B:  pos_raddr = AW'(idx_q[1]);
      S_POS_C:  pos_raddr = AW'(idx_q[2]);
      S_UPD_RD: acc_raddr = AW'(idx_q[ck_q]);
      S_UPD_WR: begin
        // a saturated corner keeps both its sums and its count
        acc_we        = acc_rd_q.cnt != '1;
        acc_wdata.sx  = acc_rd_q.sx + SUM_W'(n_q[0]);
        acc_wdata.sy  = acc_rd_q.sy + SUM_W'(n_q[1]);
        acc_wdata.sz  = acc_rd_q.sz + SUM_W'(n_q[2]);
        acc_wdata.cnt = acc_rd_q.cnt + CNT_W'(1);
      end
      S_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  // shared multiplier operands: cross terms, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQUARE) begin
      unique case (mstep_q)
        3'd0: begin mul_a = signed'({2'b00, m_q[0][29:0]}); mul_b = mul_a; end
        3'd1: begin mul_a = signed'({2'b00, m_q[1][29:0]}); mul_b = mul_a; end
        3'd2: begin mul_a = signed'({2'b00, m_q[2][29:0]}); mul_b = mul_a; end
        default: ;
      endcase
    end else begin
      unique case (mstep_q)
        3'd0: begin mul_a = ev(e_neg_q[1], e_mag_q[1]); mul_b = ev(e_neg_q[5], e_mag_q[5]); end
        3'd1: begin mul_a = ev(e_neg_q[2], e_mag_q[2]); mul_b = ev(e_neg_q[4], e_mag_q[4]); end
        3'd2: begin mul_a = ev(e_neg_q[2], e_mag_q[2]); mul_b = ev(e_neg_q[3], e_mag_q[3]); end
        3'd3: begin mul_a = ev(e_neg_q[0], e_mag_q[0]); mul_b = ev(e_neg_q[5], e_mag_q[5]); end
        3'd4: begin mul_a = ev(e_neg_q[0], e_mag_q[0]); mul_b = ev(e_neg_q[4], e_mag_q[4]); end
        3'd5: begin mul_a = ev(e_neg_q[1], e_mag_q[1]); mul_b = ev(e_neg_q[3], e_mag_q[3]); end
        default: ;
      endcase
    end
  end

  // divider operands: unit normal component or rounded average
  always_comb begin
    if (act_q == ACT_READ) begin
      div_num = DIV_NUM_W'(sum_q[ck_q][SUM_W-1] ? 32'(-sum_q[ck_q]) : 32'(sum_q[ck_q]))
              + DIV_NUM_W'(cnt_q >> 1);
      div_den = DIV_DEN_W'(cnt_q);
      q_neg   = sum_q[ck_q][SUM_W-1];
    end else begin
      div_num = DIV_NUM_W'({m_q[ck_q][29:0], 14'd0}) + DIV_NUM_W'(sq_r_q[30:1]);
      div_den = DIV_DEN_W'(sq_r_q[30:0]);
      q_neg   = cr_neg_q[ck_q];
    end
  end

  assign q16 = div_quo[NRM_W-1:0];

  svna_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      first_q     <= '0;
      vcount_q    <= '0;
      clr_addr_q  <= '0;
      ck_q        <= '0;
      mstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_FIRST_OUT:    first_q  <= cfg_i.data;
          CFG_VERTEX_COUNT: vcount_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (state_q == S_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
      unique case (state_q)
        S_DISPATCH: ck_q <= '0;
        S_ESHIFT:   mstep_q <= '0;
        S_CROSS:    mstep_q <= mstep_q + 3'd1;
        S_NORM:     mstep_q <= '0;
        S_SQUARE:   mstep_q <= mstep_q + 3'd1;
        S_DIV_WAIT: if (div_done) ck_q <= (ck_q == 2'd2) ? 2'd0 : ck_q + 2'd1;
        S_UPD_WR:   ck_q <= ck_q + 2'd1;
        default: ;
      endcase
      // a new result loads as the old one leaves
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    pos_rd_q <= pos_mem[pos_raddr];
    if (pos_we) pos_mem[AW'(idx_q[0])] <= wpos_q;
  end

  always_ff @(posedge clk_i) begin
    acc_rd_q <= acc_mem[acc_raddr];
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        act_q    <= action_e'(in_i.action);
        idx_q[0] <= in_i.first_index;
        idx_q[1] <= in_i.second_index;
        idx_q[2] <= in_i.third_index;
        wpos_q   <= '{x: in_i.pos_x, y: in_i.pos_y, z: in_i.pos_z};
      end
      S_DISPATCH: begin
        // out-of-range read answers at once with zero normals
        res_status_q <= ST_OUT_OF_RANGE;
        for (int k = 0; k < 3; k++) n_q[k] <= '0;
      end
      S_POS_B: pa_q <= pos_rd_q;
      S_POS_C: pb_q <= pos_rd_q;
      S_EDGE: begin
        // exact 33-bit edges kept as sign and magnitude
        for (int k = 0; k < 6; k++) begin
          logic signed [33:0] d;
          logic signed [31:0] p, q;
          unique case (k)
            0: begin p = pb_q.x;     q = pa_q.x; end
            1: begin p = pb_q.y;     q = pa_q.y; end
            2: begin p = pb_q.z;     q = pa_q.z; end
            3: begin p = pos_rd_q.x; q = pa_q.x; end
            4: begin p = pos_rd_q.y; q = pa_q.y; end
            default: begin p = pos_rd_q.z; q = pa_q.z; end
          endcase
          d          = 34'(p) - 34'(q);
          e_neg_q[k] <= d[33];
          e_mag_q[k] <= d[33] ? 33'(-d) : d[32:0];
        end
      end
      S_ESHIFT: begin
        // shifting the magnitude truncates toward zero
        if (e_big) begin
          for (int k = 0; k < 6; k++) e_mag_q[k] <= e_mag_q[k] >> 1;
        end
      end
      S_CROSS: begin
        if (mstep_q != 3'd0) begin
          if (!cj[0]) cr_q[cj[2:1]] <= prod_q;
          else        cr_q[cj[2:1]] <= cr_q[cj[2:1]] - prod_q;
        end
      end
      S_CRMAG: begin
        for (int k = 0; k < 3; k++) begin
          cr_neg_q[k] <= cr_q[k][63];
          m_q[k]      <= cr_q[k][63] ? 63'(-cr_q[k]) : cr_q[k][62:0];
        end
      end
      S_NORM: begin
        priority if (m_zero) begin
          // degenerate face still counts, with a zero normal
          for (int k = 0; k < 3; k++) n_q[k] <= '0;
        end else if (m_hi) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
        end else if (m_lo) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
        end else begin
          sq_x_q   <= '0;
          sq_r_q   <= '0;
          sq_bit_q <= 64'd1 << 62;
        end
      end
      S_SQUARE: if (mstep_q != 3'd0) sq_x_q <= sq_x_q + 64'(prod_q);
      S_SQRT: begin
        // one result bit per cycle
        if (sq_bit_q != '0) begin
          if (sq_x_q >= sq_t) begin
            sq_x_q <= sq_x_q - sq_t;
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
      end
      S_DIV_WAIT: if (div_done) n_q[ck_q] <= q_neg ? -signed'(q16) : signed'(q16);
      S_RD_WAIT: begin
        sum_q[0]     <= acc_rd_q.sx;
        sum_q[1]     <= acc_rd_q.sy;
        sum_q[2]     <= acc_rd_q.sz;
        cnt_q        <= acc_rd_q.cnt;
        res_status_q <= (acc_rd_q.cnt == '0) ? ST_NO_FACES : ST_OK;
      end
      S_OUT: begin
        if (out_free) begin
          out_nx_q     <= n_q[0];
          out_ny_q     <= n_q[1];
          out_nz_q     <= n_q[2];
          out_status_q <= res_status_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- ports
  assign cfg_i.ready       = 1'b1;
  assign in_i.ready        = state_q == S_IDLE;
  assign out_o.valid       = out_valid_q;
  assign out_o.normal_x    = out_nx_q;
  assign out_o.normal_y    = out_ny_q;
  assign out_o.normal_z    = out_nz_q;
  assign out_o.read_status = out_status_q;

endmodule

// ===== rtl/svna_div.sv =====
// ----------------------------------------------------------------------------
// svna_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module svna_div import svna_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] nq_q;
  logic [DEN_W-1:0] rem_q, den_q, rem_d;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, nq_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // numerator shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

// ===== rtl/svna_checker.sv =====
// ----------------------------------------------------------------------------
// svna_checker
// port-level checks of the smooth vertex normal accumulator, bound to the top
// ----------------------------------------------------------------------------
`include "smooth_vertex_normal_accumulator_macros.svh"

module svna_checker import svna_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [NRM_W-1:0] normal_x_i,
  input logic signed [NRM_W-1:0] normal_y_i,
  input logic signed [NRM_W-1:0] normal_z_i,
  input logic [1:0]              read_status_i
);

  localparam logic signed [NRM_W-1:0] NMAX = NRM_W'(NORMAL_ONE);

  `SVNA_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  `SVNA_ASSERT_IMP(a_status_zero, out_valid_i && read_status_i != ST_OK,
    normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0, "nonzero normal on bad read")

  `SVNA_ASSERT_IMP(a_norm_range, out_valid_i,
    normal_x_i <= NMAX && normal_x_i >= -NMAX && normal_y_i <= NMAX
    && normal_y_i >= -NMAX && normal_z_i <= NMAX && normal_z_i >= -NMAX,
    "normal beyond unit range")

  `SVNA_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i,
    "item taken while busy")

endmodule

bind smooth_vertex_normal_accumulator svna_checker u_svna_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .normal_x_i    (out_o.normal_x),
  .normal_y_i    (out_o.normal_y),
  .normal_z_i    (out_o.normal_z),
  .read_status_i (out_o.read_status)
);
